// File: hdl/pkis_pkg.sv
// pkis_pkg: shared types and constants for the per-key interval statistics block
// used by pkis_div and per_key_interval_stats
package pkis_pkg;

	localparam int KEY_SLOTS_DEF  = 64;
	localparam int PRICE_BITS_DEF = 32;

	localparam logic [15:0] INTERVAL_RESET = 16'd1000;
	localparam logic [6:0]  SYMBOLS_RESET  = 7'd64;

	localparam logic REG_INTERVAL = 1'b0;
	localparam logic REG_SYMBOLS  = 1'b1;

	localparam logic CMD_TRADE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRADE,
		ST_ROW_RD,
		ST_ROW_ST,
		ST_ROW_DIV
	} pkis_state_t;

endpackage

// File: hdl/pkis_div.sv
// pkis_div: 64 by 32 bit restoring divider, one quotient bit per cycle
// depends on pkis_pkg
module pkis_div import pkis_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   dividend,
	input  logic [31:0]   divisor,
	output logic          done,
	output logic [63:0]   quotient
);

	logic        run_q;
	logic [5:0]  step_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] dvs_q;
	logic        done_q;
	logic [32:0] shifted;
	logic        fits;

	assign shifted = {rem_q, quo_q[63]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hdl/per_key_interval_stats.sv
// per_key_interval_stats: per-key trade statistics table with periodic snapshots
// trade: memory read, then modify and write back; tick without publication: taken without leaving idle
// publication: each key passes ST_ROW_RD and ST_ROW_ST; a key with trades adds a bit-serial 64/32 divide
// a row is strobed on result_valid for one cycle; the receiver cannot stall
// reset clears control state and the per-entry valid bits, so the table reads as cleared at once
// depends on pkis_pkg and pkis_div
module per_key_interval_stats import pkis_pkg::*; #(
	parameter int KEY_SLOTS  = KEY_SLOTS_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [5:0]  symbol_index,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic [5:0]  key_index,
	output logic [31:0] trade_count,
	output logic [31:0] last_trade_price,
	output logic [63:0] volume_sum,
	output logic [31:0] average_price,
	output logic [31:0] lowest_price,
	output logic [31:0] highest_price,
	output logic        final_row
);

	localparam int AW  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int KW  = $clog2(KEY_SLOTS + 1);
	localparam int CW  = (KW > 7) ? KW : 7;
	localparam int PB  = PRICE_BITS;
	localparam logic [PB-1:0] PRICE_MAX = {PB{1'b1}};

	typedef struct packed {
		logic [31:0]   cnt;
		logic [PB-1:0] last;
		logic [63:0]   vol;
		logic [63:0]   psum;
		logic [PB-1:0] low;
		logic [PB-1:0] high;
	} entry_t;

	entry_t mem [KEY_SLOTS];
	logic [KEY_SLOTS-1:0] ivalid_q, lvalid_q;

	pkis_state_t state_q, state_d;
	logic [15:0] interval_q;
	logic [6:0]  symbols_q;
	logic [15:0] tick_q;
	logic [AW-1:0] addr_q, key_q, rd_addr;
	logic [PB-1:0] price_q;
	logic [PB+31:0] prod_q;
	entry_t rd_q, cur, upd;
	logic rd_iv_q, rd_lv_q;

	logic [CW-1:0] keys;
	logic [CW-1:0] sym_ext;
	logic [16:0]   tick_next, limit;
	logic          accept, trade_ok, fire, last_key;
	logic [PB-1:0] price_in;
	logic [64:0]   vol_add, psum_add;
	logic [63:0]   quotient;
	logic [PB-1:0] avg;
	logic          emit, clear_all;
	logic          div_start, div_done;

	assign sym_ext  = CW'(symbols_q);
	assign keys     = (sym_ext > CW'(KEY_SLOTS)) ? CW'(KEY_SLOTS) : sym_ext;
	assign accept   = start && !busy;
	assign price_in = price[PB-1:0];
	assign trade_ok = CW'(symbol_index) < keys;
	assign tick_next = 17'(tick_q) + 17'd1;
	assign limit    = (interval_q == 16'd0) ? 17'd1 : 17'(interval_q);
	assign fire     = tick_next >= limit;
	assign last_key = (CW'(key_q) + CW'(1)) == keys;
	assign rd_addr  = (state_q == ST_IDLE) ? AW'(symbol_index) : key_q;

	// invalid entries read as their cleared values
	always_comb begin
		cur = rd_q;
		if (!rd_iv_q) begin
			cur.cnt  = '0;
			cur.vol  = '0;
			cur.psum = '0;
			cur.low  = '1;
			cur.high = '0;
		end
		if (!rd_lv_q)
			cur.last = '0;
	end

	always_comb begin
		vol_add  = {1'b0, cur.vol} + 65'(prod_q);
		psum_add = {1'b0, cur.psum} + 65'(price_q);
		upd      = cur;
		upd.cnt  = (cur.cnt == '1) ? cur.cnt : cur.cnt + 32'd1;
		upd.last = price_q;
		upd.vol  = vol_add[64] ? '1 : vol_add[63:0];
		upd.psum = psum_add[64] ? '1 : psum_add[63:0];
		upd.low  = (price_q < cur.low) ? price_q : cur.low;
		upd.high = (price_q > cur.high) ? price_q : cur.high;
	end

	assign avg = (quotient > 64'(PRICE_MAX)) ? PRICE_MAX : quotient[PB-1:0];

	pkis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cur.psum),
		.divisor  (cur.cnt),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		emit      = 1'b0;
		clear_all = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_TRADE) begin
						if (trade_ok)
							state_d = ST_TRADE;
					end else if (fire) begin
						if (keys == '0)
							clear_all = 1'b1;
						else
							state_d = ST_ROW_RD;
					end
				end
			end
			ST_TRADE:  state_d = ST_IDLE;
			ST_ROW_RD: state_d = ST_ROW_ST;
			ST_ROW_ST: begin
				if (cur.cnt == '0) begin
					emit = 1'b1;
				end else begin
					div_start = 1'b1;
					state_d = ST_ROW_DIV;
				end
			end
			ST_ROW_DIV: emit = div_done;
			default: state_d = ST_IDLE;
		endcase
		if (emit) begin
			if (last_key) begin
				clear_all = 1'b1;
				state_d = ST_IDLE;
			end else begin
				state_d = ST_ROW_RD;
			end
		end
	end

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			interval_q   <= INTERVAL_RESET;
			symbols_q    <= SYMBOLS_RESET;
			tick_q       <= '0;
			key_q        <= '0;
			ivalid_q     <= '0;
			lvalid_q     <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= emit;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INTERVAL: interval_q <= cfg_data;
					REG_SYMBOLS:  symbols_q  <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (accept && command == CMD_TICK)
				tick_q <= fire ? 16'd0 : tick_next[15:0];
			if (accept)
				key_q <= '0;
			else if (emit)
				key_q <= key_q + AW'(1);
			if (state_q == ST_TRADE) begin
				ivalid_q[addr_q] <= 1'b1;
				lvalid_q[addr_q] <= 1'b1;
			end
			if (clear_all)
				ivalid_q <= '0;
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		rd_q    <= mem[rd_addr];
		rd_iv_q <= ivalid_q[rd_addr];
		rd_lv_q <= lvalid_q[rd_addr];
		if (state_q == ST_TRADE)
			mem[addr_q] <= upd;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= AW'(symbol_index);
			price_q <= price_in;
			prod_q  <= price_in * quantity;
		end
		if (emit) begin
			key_index        <= 6'(key_q);
			trade_count      <= cur.cnt;
			last_trade_price <= 32'(cur.last);
			volume_sum       <= cur.vol;
			average_price    <= (cur.cnt == '0) ? 32'd0 : 32'(avg);
			lowest_price     <= (cur.cnt == '0) ? 32'd0 : 32'(cur.low);
			highest_price    <= (cur.cnt == '0) ? 32'd0 : 32'(cur.high);
			final_row        <= last_key;
		end
	end

	a_row_from_pub: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(state_q) == ST_ROW_ST || $past(state_q) == ST_ROW_DIV))
		else $error("row strobed outside a publication");
	a_trade_two: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TRADE |=> state_q == ST_IDLE)
		else $error("trade write-back did not finish");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_ROW_DIV)
		else $error("divider finished outside row division");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && final_row) |-> state_q == ST_IDLE)
		else $error("publication did not end after final row");

endmodule

// File: tb/sv/pkis_checker.sv
`timescale 1ns / 100ps
// pkis_checker: watches the command, config and snapshot ports of per_key_interval_stats,
// predicts every snapshot row and compares it field by field; depends on pkis_pkg
module pkis_checker import pkis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        command,
	input  logic [5:0]  symbol_index,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        result_valid,
	input  logic [5:0]  key_index,
	input  logic [31:0] trade_count,
	input  logic [31:0] last_trade_price,
	input  logic [63:0] volume_sum,
	input  logic [31:0] average_price,
	input  logic [31:0] lowest_price,
	input  logic [31:0] highest_price,
	input  logic        final_row,
	output int          error_count,
	output int          rows_pending,
	output int          rows_seen
);

	typedef struct packed {
		logic [5:0]  key;
		logic [31:0] count;
		logic [31:0] last;
		logic [63:0] volume;
		logic [31:0] avg;
		logic [31:0] low;
		logic [31:0] high;
		logic        last_row;
	} snapshot_row_t;

	snapshot_row_t snapshot_q[$];

	logic [31:0] trades_tbl[64];
	logic [31:0] last_tbl[64];
	logic [63:0] vol_tbl[64];
	logic [63:0] psum_tbl[64];
	logic [31:0] low_tbl[64];
	logic [31:0] high_tbl[64];
	logic [15:0] ticks;
	logic [15:0] interval_reg;
	logic [6:0]  symbols_reg;

	assign rows_pending = snapshot_q.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
		error_count++;
	endtask

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic void clear_table();
		for (int k = 0; k < 64; k++) begin
			trades_tbl[k] = '0;
			vol_tbl[k] = '0;
			psum_tbl[k] = '0;
			low_tbl[k] = '1;
			high_tbl[k] = '0;
		end
	endfunction

	function automatic int keys_used();
		return (symbols_reg > 7'd64) ? 64 : int'(symbols_reg);
	endfunction

	function automatic void add_trade(input logic [5:0] k, input logic [31:0] p,
			input logic [31:0] q);
		if (int'(k) >= keys_used())
			return;
		if (trades_tbl[k] != '1)
			trades_tbl[k]++;
		last_tbl[k] = p;
		vol_tbl[k] = sat_add(vol_tbl[k], {32'b0, p} * {32'b0, q});
		psum_tbl[k] = sat_add(psum_tbl[k], {32'b0, p});
		if (p < low_tbl[k])
			low_tbl[k] = p;
		if (p > high_tbl[k])
			high_tbl[k] = p;
	endfunction

	function automatic void count_tick();
		logic [16:0] lim;
		logic [16:0] nxt;
		logic [63:0] quot;
		snapshot_row_t r;
		int n;
		lim = (interval_reg == '0) ? 17'd1 : {1'b0, interval_reg};
		nxt = {1'b0, ticks} + 17'd1;
		if (nxt < lim) begin
			ticks = nxt[15:0];
			return;
		end
		ticks = '0;
		n = keys_used();
		for (int k = 0; k < n; k++) begin
			quot = '0;
			if (trades_tbl[k] != '0) begin
				quot = psum_tbl[k] / {32'b0, trades_tbl[k]};
				if (quot > 64'hFFFF_FFFF)
					quot = 64'hFFFF_FFFF;
			end
			r.key = k[5:0];
			r.count = trades_tbl[k];
			r.last = last_tbl[k];
			r.volume = vol_tbl[k];
			r.avg = quot[31:0];
			r.low = (trades_tbl[k] != '0) ? low_tbl[k] : '0;
			r.high = (trades_tbl[k] != '0) ? high_tbl[k] : '0;
			r.last_row = (k + 1 == n);
			snapshot_q.push_back(r);
		end
		clear_table();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			for (int k = 0; k < 64; k++)
				last_tbl[k] = '0;
			ticks = '0;
			interval_reg = INTERVAL_RESET;
			symbols_reg = SYMBOLS_RESET;
			snapshot_q.delete();
			error_count = 0;
			rows_seen = 0;
		end else begin
			if (result_valid) begin
				rows_seen++;
				if (snapshot_q.size() == 0) begin
					report("unexpected row, key", key_index, 0);
				end else begin
					snapshot_row_t w;
					w = snapshot_q.pop_front();
					if (key_index !== w.key) report("key_index", key_index, w.key);
					if (trade_count !== w.count) report("trade_count", trade_count, w.count);
					if (last_trade_price !== w.last)
						report("last_trade_price", last_trade_price, w.last);
					if (volume_sum !== w.volume) report("volume_sum", volume_sum, w.volume);
					if (average_price !== w.avg) report("average_price", average_price, w.avg);
					if (lowest_price !== w.low) report("lowest_price", lowest_price, w.low);
					if (highest_price !== w.high) report("highest_price", highest_price, w.high);
					if (final_row !== w.last_row) report("final_row", final_row, w.last_row);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_INTERVAL)
					interval_reg = cfg_data;
				else
					symbols_reg = cfg_data[6:0];
			end
			if (start && !busy) begin
				if (command == CMD_TRADE)
					add_trade(symbol_index, price, quantity);
				else
					count_tick();
			end
		end
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for per_key_interval_stats
// depends on pkis_pkg, the block itself and pkis_checker
module tb_top;
	import pkis_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [5:0]  symbol_index;
	logic [31:0] price;
	logic [31:0] quantity;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        result_valid;
	logic [5:0]  key_index;
	logic [31:0] trade_count;
	logic [31:0] last_trade_price;
	logic [63:0] volume_sum;
	logic [31:0] average_price;
	logic [31:0] lowest_price;
	logic [31:0] highest_price;
	logic        final_row;
	int          error_count;
	int          rows_pending;
	int          rows_seen;
	int          items_sent;
	int          quiet_cycles;
	bit          no_gaps;

	per_key_interval_stats u_top (.*);
	pkis_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// watchdog: cycles with no transaction and no row
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 4000) begin
			$display("timeout waiting on the block");
			$display("FAIL");
			$finish;
		end
	end

	task automatic send(input logic cmd, input logic [5:0] key, input logic [31:0] p,
			input logic [31:0] q);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		symbol_index <= key;
		price <= p;
		quantity <= q;
		// busy only moves on the rising edge, so the falling edge shows the sampled value
		do @(negedge clk); while (busy);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		start <= 1'b0;
		@(posedge clk);
		while (rows_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int sym;
		int key_hi;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_TRADE;
		symbol_index = '0;
		price = '0;
		quantity = '0;
		cfg_we = 1'b0;
		cfg_index = REG_INTERVAL;
		cfg_data = '0;
		items_sent = 0;
		no_gaps = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, saturation, unused keys, empty intervals
		write_reg(REG_INTERVAL, 16'd1);
		write_reg(REG_SYMBOLS, 16'd3);
		send(CMD_TRADE, 6'd0, 32'd0, 32'd0);
		send(CMD_TRADE, 6'd0, '1, '1);
		send(CMD_TRADE, 6'd0, '1, '1);
		send(CMD_TRADE, 6'd1, 32'd5, 32'd7);
		send(CMD_TRADE, 6'd1, 32'd8, 32'd1);
		send(CMD_TRADE, 6'd2, 32'h8000_0000, 32'd2);
		send(CMD_TRADE, 6'd3, 32'd9, 32'd9);
		send(CMD_TRADE, 6'd63, 32'd9, 32'd9);
		send(CMD_TICK, 6'd63, '1, '1);
		send(CMD_TICK, 6'd0, 32'd0, 32'd0);
		write_reg(REG_INTERVAL, 16'd0);
		send(CMD_TRADE, 6'd2, 32'd1, 32'd1);
		send(CMD_TICK, 6'd0, 32'd0, 32'd0);
		write_reg(REG_SYMBOLS, 16'd0);
		send(CMD_TRADE, 6'd0, 32'd4, 32'd4);
		send(CMD_TICK, 6'd0, 32'd0, 32'd0);
		write_reg(REG_SYMBOLS, 16'd127);
		send(CMD_TRADE, 6'd63, 32'hAAAA_5555, 32'h5555_AAAA);
		send(CMD_TRADE, 6'd42, 32'h5555_AAAA, 32'hAAAA_5555);
		send(CMD_TICK, 6'd0, 32'd0, 32'd0);
		write_reg(REG_INTERVAL, 16'hFFFF);
		send(CMD_TICK, 6'd0, 32'd0, 32'd0);
		send(CMD_TICK, 6'd0, 32'd0, 32'd0);
		send(CMD_TICK, 6'd0, 32'd0, 32'd0);
		// lowered below the running count: the next tick publishes
		write_reg(REG_INTERVAL, 16'd2);
		send(CMD_TRADE, 6'd7, 32'd100, 32'd3);
		send(CMD_TICK, 6'd0, 32'd0, 32'd0);

		// random phases with a fresh setting each
		while (items_sent < 460) begin
			case ($urandom_range(0, 5))
				0: sym = 1;
				1: sym = 64;
				2: sym = $urandom_range(65, 127);
				default: sym = $urandom_range(1, 16);
			endcase
			write_reg(REG_SYMBOLS, sym[15:0]);
			write_reg(REG_INTERVAL, 16'($urandom_range(0, 6)));
			no_gaps = ($urandom_range(0, 3) == 0);
			key_hi = (sym > 60) ? 63 : sym + 2;
			repeat ($urandom_range(20, 45)) begin
				if ($urandom_range(0, 3) == 0)
					send(CMD_TICK, 6'($urandom), $urandom, $urandom);
				else if ($urandom_range(0, 7) == 0)
					send(CMD_TRADE, 6'($urandom), pick_value(), pick_value());
				else
					send(CMD_TRADE, 6'($urandom_range(0, key_hi)), pick_value(), pick_value());
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (rows_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d transactions sent, %0d snapshot rows checked, %0d mismatches",
			items_sent, rows_seen, error_count);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: per_key_interval_stats.f
hdl/pkis_pkg.sv
hdl/pkis_div.sv
hdl/per_key_interval_stats.sv
tb/sv/pkis_checker.sv
tb/sv/tb_top.sv
